@@ src/vkp_pkg.sv @@
package vkp_pkg;

    localparam int MAX_REL   = 8;
    localparam int NUM_BITS  = 32;
    localparam int STK_DEPTH = 16;
    localparam int SP_W      = $clog2(STK_DEPTH + 1);
    localparam int REL_IW    = (MAX_REL > 1) ? $clog2(MAX_REL) : 1;
    localparam int RC_W      = $clog2(MAX_REL + 1);
    localparam int STEP_W    = $clog2(MAX_REL + 4);
    localparam int WBUF_N    = 8;
    localparam int N_WORDS   = 12;
    localparam int WMAX      = 7;

    typedef logic [NUM_BITS-1:0] t_num;
    localparam t_num NUM_MAX = '1;

    localparam logic [2:0] KIND_EPOCH   = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_PRE     = 3'd2;
    localparam logic [2:0] KIND_POST    = 3'd3;
    localparam logic [2:0] KIND_DEV     = 3'd4;
    localparam logic [2:0] KIND_INVALID = 3'd5;

    localparam logic [2:0] RANK_DEV_ONLY = 3'd0;
    localparam logic [2:0] RANK_NONE     = 3'd4;

    localparam logic [2:0] QS_POST = 3'd5;
    localparam logic [2:0] QS_DEV  = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UV     = 8'h56;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_LV     = 8'h76;

    localparam logic [7:0] QWORD [N_WORDS][WMAX] = '{
        '{"a", "l", "p", "h", "a", 8'h00, 8'h00},
        '{"b", "e", "t", "a", 8'h00, 8'h00, 8'h00},
        '{"p", "r", "e", "v", "i", "e", "w"},
        '{"p", "r", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "o", "s", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "v", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "v", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] QLEN [N_WORDS] = '{
        4'd5, 4'd4, 4'd7, 4'd3, 4'd2, 4'd4, 4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1
    };
    localparam logic [2:0] QEFF [N_WORDS] = '{
        3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd6, 3'd1, 3'd2, 3'd3, 3'd5
    };

    typedef enum logic [3:0] {
        PH_LEAD, PH_AFTER_V, PH_FIRST, PH_BANG, PH_REL, PH_RDOT, PH_QTOP,
        PH_QSEP, PH_QWORD, PH_QAFTER, PH_QASEP, PH_QNUM, PH_TAIL,
        PH_FIN_OK, PH_FIN_BAD
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  key_kind;
        logic [2:0]  qual_rank;
        logic [31:0] number;
        logic        present;
        logic        run_end;
    } t_out_item;

    typedef struct packed {
        logic                   bad;
        t_num                   epoch;
        t_num [MAX_REL-1:0]     rel;
        logic [RC_W-1:0]        rel_count;
        logic [2:0]             pre_kind;
        t_num                   pre_value;
        logic                   post_present;
        t_num                   post_value;
        logic                   dev_present;
        t_num                   dev_value;
    } t_key;

    function automatic t_num sat_acc(input t_num a, input logic [3:0] d);
        logic [NUM_BITS+3:0] p;
        p = ({4'b0, a} << 3) + ({4'b0, a} << 1) + (NUM_BITS + 4)'(d);
        return (p > {4'b0, NUM_MAX}) ? NUM_MAX : p[NUM_BITS-1:0];
    endfunction

endpackage

@@ src/vkp_front.sv @@
module vkp_front
    import vkp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_key     o_key
);

    logic [7:0]      r_stk [STK_DEPTH];
    logic [7:0]      n_stk [STK_DEPTH];
    logic [SP_W-1:0] r_sp, n_sp;
    logic            r_final, n_final;
    logic            r_end, n_end;
    logic            r_rp, n_rp;
    logic [2:0]      r_rp_idx, n_rp_idx;
    logic [2:0]      r_rp_low, n_rp_low;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_wm, n_wm;
    t_num            r_accum, n_accum;
    t_num            r_epoch, n_epoch;
    t_num            r_rel [MAX_REL];
    logic [RC_W-1:0] r_rel_cnt, n_rel_cnt;
    logic [2:0]      r_pre_kind, n_pre_kind;
    t_num            r_pre_val, n_pre_val;
    logic            r_post_p, n_post_p;
    t_num            r_post_v, n_post_v;
    logic            r_dev_p, n_dev_p;
    t_num            r_dev_v, n_dev_v;
    logic            r_pre_seen, n_pre_seen;
    logic            r_impl, n_impl;
    logic [7:0]      r_wbuf [WBUF_N];
    logic [2:0]      r_qual, n_qual;
    logic [7:0]      r_held, n_held;

    logic            rel_we;
    logic            wb_we;
    logic            accept;
    logic            op_pop;
    logic            op_push;
    logic [7:0]      push_val;

    logic [7:0]      c;
    logic [7:0]      lc;
    logic            dig;
    logic            sep;
    logic [3:0]      d;
    logic [3:0]      t;
    logic [7:0]      wb [WMAX];
    logic            m_found;
    logic            m_partial;
    logic            m_hit;
    logic [2:0]      m_sel;
    logic [3:0]      m_len;
    logic            ok;

    assign c   = r_stk[0];
    assign dig = (c >= CH_0) && (c <= CH_9);
    assign sep = (c == CH_DOT) || (c == CH_DASH) || (c == CH_USCORE);
    assign d   = c[3:0];
    assign lc  = ((c >= CH_UA) && (c <= CH_UZ)) ? c + 8'd32 : c;
    assign t   = {1'b0, r_wm} + 4'd1;

    assign o_in_ready = (r_sp == '0) && !r_rp && !r_final && !r_end;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        for (int j = 0; j < WMAX; j++) begin
            wb[j] = (3'(j) == r_wm) ? lc : r_wbuf[j];
        end
        m_found   = 1'b0;
        m_partial = 1'b0;
        m_hit     = 1'b0;
        m_sel     = '0;
        m_len     = '0;
        for (int i = 0; i < N_WORDS; i++) begin
            ok = 1'b1;
            for (int j = 0; j < WMAX; j++) begin
                if ((4'(j) < QLEN[i]) && (4'(j) < t) && (QWORD[i][j] != wb[j])) begin
                    ok = 1'b0;
                end
            end
            if (!m_found && ok) begin
                m_found = 1'b1;
                if (QLEN[i] > t) begin
                    m_partial = 1'b1;
                end else begin
                    m_hit = 1'b1;
                    m_sel = QEFF[i];
                    m_len = QLEN[i];
                end
            end
        end
    end

    always_comb begin
        logic       do_commit;
        logic       cm_push;
        logic       cm_clr;
        t_num       cm_num;
        logic       do_finish;
        n_sp = r_sp;
        n_final = r_final;
        n_end = r_end;
        n_rp = r_rp;
        n_rp_idx = r_rp_idx;
        n_rp_low = r_rp_low;
        n_phase = r_phase;
        n_wm = r_wm;
        n_accum = r_accum;
        n_epoch = r_epoch;
        n_rel_cnt = r_rel_cnt;
        n_pre_kind = r_pre_kind;
        n_pre_val = r_pre_val;
        n_post_p = r_post_p;
        n_post_v = r_post_v;
        n_dev_p = r_dev_p;
        n_dev_v = r_dev_v;
        n_pre_seen = r_pre_seen;
        n_impl = r_impl;
        n_qual = r_qual;
        n_held = r_held;
        rel_we = 1'b0;
        wb_we = 1'b0;
        op_pop = 1'b0;
        op_push = 1'b0;
        push_val = c;
        o_push = 1'b0;
        do_commit = 1'b0;
        cm_push = 1'b0;
        cm_clr = 1'b0;
        cm_num = '0;
        do_finish = 1'b0;

        if (accept) begin
            op_push = 1'b1;
            push_val = i_in.char_code;
            n_final = i_in.final_char;
        end else if (r_rp) begin
            op_push = 1'b1;
            push_val = r_wbuf[r_rp_idx];
            if (r_rp_idx == r_rp_low) begin
                n_rp = 1'b0;
            end else begin
                n_rp_idx = r_rp_idx - 3'd1;
            end
        end else if (r_sp != '0) begin
            unique case (r_phase)
                PH_LEAD: begin
                    op_pop = 1'b1;
                    if ((c == CH_LV) || (c == CH_UV)) begin
                        n_phase = PH_AFTER_V;
                    end else if (dig) begin
                        n_accum = NUM_BITS'(d);
                        n_phase = PH_FIRST;
                    end else if ((c != CH_SPACE) && (c != CH_TAB)) begin
                        n_phase = PH_FIN_BAD;
                    end
                end
                PH_AFTER_V, PH_BANG: begin
                    op_pop = 1'b1;
                    if (dig) begin
                        n_accum = NUM_BITS'(d);
                        n_phase = (r_phase == PH_AFTER_V) ? PH_FIRST : PH_REL;
                    end else begin
                        n_phase = PH_FIN_BAD;
                    end
                end
                PH_FIRST: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        n_accum = sat_acc(r_accum, d);
                    end else if (c == CH_BANG) begin
                        op_pop = 1'b1;
                        n_epoch = r_accum;
                        n_accum = '0;
                        n_phase = PH_BANG;
                    end else begin
                        n_phase = PH_REL;
                    end
                end
                PH_REL: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        n_accum = sat_acc(r_accum, d);
                    end else begin
                        if (r_rel_cnt < RC_W'(MAX_REL)) begin
                            rel_we = 1'b1;
                            n_rel_cnt = r_rel_cnt + 1'b1;
                        end
                        n_accum = '0;
                        if (c == CH_DOT) begin
                            op_pop = 1'b1;
                            n_phase = PH_RDOT;
                        end else begin
                            n_phase = PH_QTOP;
                        end
                    end
                end
                PH_RDOT: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        if (r_rel_cnt >= RC_W'(MAX_REL)) begin
                            n_phase = PH_FIN_BAD;
                        end else begin
                            n_accum = NUM_BITS'(d);
                            n_phase = PH_REL;
                        end
                    end else begin
                        op_push = 1'b1;
                        push_val = CH_DOT;
                        n_phase = PH_QTOP;
                    end
                end
                PH_QTOP: begin
                    if (c == CH_NUL) begin
                        op_pop = 1'b1;
                        do_finish = 1'b1;
                    end else if (c == CH_PLUS) begin
                        op_pop = 1'b1;
                        n_phase = PH_TAIL;
                    end else begin
                        n_impl = (c == CH_DASH);
                        n_phase = PH_QSEP;
                        op_pop = sep;
                    end
                end
                PH_QSEP: begin
                    if (sep) begin
                        op_pop = 1'b1;
                    end else if (c == CH_NUL) begin
                        op_pop = 1'b1;
                        do_finish = 1'b1;
                    end else if (c == CH_PLUS) begin
                        op_pop = 1'b1;
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase = PH_QWORD;
                        n_wm = '0;
                    end
                end
                PH_QWORD: begin
                    op_pop = 1'b1;
                    wb_we = 1'b1;
                    if (m_partial) begin
                        n_wm = t[2:0];
                    end else if (m_hit || (r_impl && (wb[0] >= CH_0) && (wb[0] <= CH_9))) begin
                        n_qual = m_hit ? m_sel : QS_POST;
                        n_wm = '0;
                        n_phase = PH_QAFTER;
                        if ((m_hit ? m_len : 4'd0) < t) begin
                            n_rp = 1'b1;
                            n_rp_idx = r_wm;
                            n_rp_low = m_hit ? m_len[2:0] : 3'd0;
                        end
                    end else begin
                        n_phase = PH_FIN_BAD;
                    end
                end
                PH_QAFTER: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        n_accum = NUM_BITS'(d);
                        n_phase = PH_QNUM;
                    end else if (sep) begin
                        op_pop = 1'b1;
                        n_held = c;
                        n_phase = PH_QASEP;
                    end else begin
                        do_commit = 1'b1;
                    end
                end
                PH_QASEP: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        n_accum = NUM_BITS'(d);
                        n_phase = PH_QNUM;
                    end else begin
                        do_commit = 1'b1;
                        cm_push = 1'b1;
                    end
                end
                PH_QNUM: begin
                    if (dig) begin
                        op_pop = 1'b1;
                        n_accum = sat_acc(r_accum, d);
                    end else begin
                        do_commit = 1'b1;
                        cm_num = r_accum;
                        cm_clr = 1'b1;
                    end
                end
                PH_TAIL: begin
                    op_pop = 1'b1;
                    do_finish = (c == CH_NUL);
                end
                default: begin
                    op_pop = 1'b1;
                end
            endcase

            if (do_commit) begin
                if ((r_qual != QS_POST) && (r_qual != QS_DEV) && r_pre_seen) begin
                    op_pop = 1'b1;
                    n_phase = PH_FIN_BAD;
                end else begin
                    if (r_qual == QS_POST) begin
                        n_post_p = 1'b1;
                        n_post_v = cm_num;
                    end else if (r_qual == QS_DEV) begin
                        n_dev_p = 1'b1;
                        n_dev_v = cm_num;
                    end else begin
                        n_pre_seen = 1'b1;
                        n_pre_kind = r_qual;
                        n_pre_val = cm_num;
                    end
                    if (cm_clr) begin
                        n_accum = '0;
                    end
                    if (cm_push) begin
                        op_push = 1'b1;
                        push_val = r_held;
                    end
                    n_phase = PH_QTOP;
                end
            end

            if (do_finish) begin
                if (!r_pre_seen && r_dev_p && !r_post_p) begin
                    n_pre_kind = RANK_DEV_ONLY;
                end
                n_phase = PH_FIN_OK;
            end
        end else if (r_final) begin
            op_push = 1'b1;
            push_val = CH_NUL;
            n_final = 1'b0;
            n_end = 1'b1;
        end else if (r_end && !i_full) begin
            o_push = 1'b1;
            n_end = 1'b0;
            n_phase = PH_LEAD;
            n_wm = '0;
            n_accum = '0;
            n_epoch = '0;
            n_rel_cnt = '0;
            n_pre_kind = RANK_NONE;
            n_pre_val = '0;
            n_post_p = 1'b0;
            n_post_v = '0;
            n_dev_p = 1'b0;
            n_dev_v = '0;
            n_pre_seen = 1'b0;
            n_impl = 1'b0;
            n_qual = '0;
            n_held = '0;
        end

        for (int i = 0; i < STK_DEPTH; i++) begin
            n_stk[i] = r_stk[i];
        end
        if (op_push) begin
            n_stk[0] = push_val;
            for (int i = 1; i < STK_DEPTH; i++) begin
                n_stk[i] = r_stk[i-1];
            end
            if (r_sp != SP_W'(STK_DEPTH)) begin
                n_sp = r_sp + 1'b1;
            end
        end else if (op_pop) begin
            for (int i = 0; i < STK_DEPTH - 1; i++) begin
                n_stk[i] = r_stk[i+1];
            end
            n_sp = r_sp - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_final <= 1'b0;
            r_end <= 1'b0;
            r_rp <= 1'b0;
            r_rp_idx <= '0;
            r_rp_low <= '0;
            r_phase <= PH_LEAD;
            r_wm <= '0;
            r_accum <= '0;
            r_epoch <= '0;
            r_rel_cnt <= '0;
            r_pre_kind <= RANK_NONE;
            r_pre_val <= '0;
            r_post_p <= 1'b0;
            r_post_v <= '0;
            r_dev_p <= 1'b0;
            r_dev_v <= '0;
            r_pre_seen <= 1'b0;
            r_impl <= 1'b0;
            r_qual <= '0;
            r_held <= '0;
        end else begin
            r_sp <= n_sp;
            r_final <= n_final;
            r_end <= n_end;
            r_rp <= n_rp;
            r_rp_idx <= n_rp_idx;
            r_rp_low <= n_rp_low;
            r_phase <= n_phase;
            r_wm <= n_wm;
            r_accum <= n_accum;
            r_epoch <= n_epoch;
            r_rel_cnt <= n_rel_cnt;
            r_pre_kind <= n_pre_kind;
            r_pre_val <= n_pre_val;
            r_post_p <= n_post_p;
            r_post_v <= n_post_v;
            r_dev_p <= n_dev_p;
            r_dev_v <= n_dev_v;
            r_pre_seen <= n_pre_seen;
            r_impl <= n_impl;
            r_qual <= n_qual;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STK_DEPTH; i++) begin
            r_stk[i] <= n_stk[i];
        end
        if (rel_we) begin
            r_rel[REL_IW'(r_rel_cnt)] <= r_accum;
        end
        if (wb_we) begin
            r_wbuf[r_wm] <= lc;
        end
    end

    always_comb begin
        o_key.bad = (r_phase != PH_FIN_OK);
        o_key.epoch = r_epoch;
        for (int i = 0; i < MAX_REL; i++) begin
            o_key.rel[i] = r_rel[i];
        end
        o_key.rel_count = r_rel_cnt;
        o_key.pre_kind = r_pre_kind;
        o_key.pre_value = r_pre_val;
        o_key.post_present = r_post_p;
        o_key.post_value = r_post_v;
        o_key.dev_present = r_dev_p;
        o_key.dev_value = r_dev_v;
    end

endmodule

@@ src/vkp_queue.sv @@
module vkp_queue
    import vkp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_key i_key,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_key o_key
);

    t_key       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_key   = r_q[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_key;
        end
    end

endmodule

@@ src/vkp_back.sv @@
module vkp_back
    import vkp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_key      i_key,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] rc;
    t_num              num;

    assign rc = STEP_W'(i_key.rel_count);
    assign o_out_valid = i_valid;

    always_comb begin
        o_out = '0;
        num = '0;
        if (i_key.bad) begin
            o_out.key_kind = KIND_INVALID;
            o_out.run_end = 1'b1;
        end else if (r_step == '0) begin
            o_out.key_kind = KIND_EPOCH;
            num = i_key.epoch;
        end else if (r_step <= rc) begin
            o_out.key_kind = KIND_RELEASE;
            num = i_key.rel[REL_IW'(r_step - 1'b1)];
        end else if (r_step == rc + 1'b1) begin
            o_out.key_kind = KIND_PRE;
            o_out.qual_rank = i_key.pre_kind;
            num = i_key.pre_value;
        end else if (r_step == rc + 2'd2) begin
            o_out.key_kind = KIND_POST;
            o_out.present = i_key.post_present;
            num = i_key.post_value;
        end else begin
            o_out.key_kind = KIND_DEV;
            o_out.present = i_key.dev_present;
            o_out.run_end = 1'b1;
            num = i_key.dev_value;
        end
        o_out.number = 32'(num);
    end

    assign o_pop = i_valid && i_out_ready && o_out.run_end;

    always_comb begin
        n_step = r_step;
        if (i_valid && i_out_ready) begin
            n_step = o_out.run_end ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ src/version_key_parser.sv @@
// Version string parser. Characters enter one per item; an accepted character
// is parsed in the cycle after it is taken, and the input is not ready again
// until it has been parsed. A character can be looked at again after a phase
// change, and a finished qualifier word pushes its leftover letters back one at
// a time before those letters are parsed again. After the final character the
// parser inserts the end marker, parses it and passes the key on, waiting while
// the key queue is full; it then accepts the next string while the key run
// (epoch, one item per release part, pre, post and dev, or a single invalid
// item) drains from a two-key queue at one item per cycle while the output is
// ready.
module version_key_parser
    import vkp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic f_push;
    t_key f_key;
    logic q_full;
    logic q_valid;
    t_key q_key;
    logic b_pop;

    vkp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (q_full),
        .o_push     (f_push),
        .o_key      (f_key)
    );

    vkp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_key   (f_key),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_key   (q_key)
    );

    vkp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_key       (q_key),
        .o_pop       (b_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_dev_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.key_kind == KIND_DEV) |-> o_out.run_end)
        else $error("dev item does not end the run");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.run_end |=> o_out_valid)
        else $error("key run broken before its end");

    a_pre_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out.key_kind == KIND_PRE)
        |=> o_out.key_kind == KIND_POST)
        else $error("post item does not follow pre item");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("key pushed into a full queue");

endmodule

@@ verif/version_key_parser_tb.sv @@
module version_key_parser_tb;
    import vkp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 370;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint unsigned NUM_TOP = 64'hFFFF_FFFF;

    class vkp_scoreboard;
        t_phase            ph;
        int unsigned       wm;
        longint unsigned   acc, epoch, pre_val, post_val, dev_val;
        longint unsigned   rel [MAX_REL];
        int                rel_cnt;
        logic [2:0]        pre_kind;
        bit                pre_seen, post_on, dev_on, dash_post;
        byte unsigned      wbuf [8];
        logic [2:0]        qsel;
        byte unsigned      held_sep;
        string             words [12];
        logic [2:0]        effect [12];
        t_out_item         key_q [$];
        int                mismatches, items, keys_seen, strings_done, invalid_runs;

        function new();
            words  = '{"alpha", "beta", "preview", "pre", "rc", "post", "rev", "dev",
                       "a", "b", "c", "r"};
            effect = '{3'd1, 3'd2, 3'd3, 3'd3, 3'd3, QS_POST, QS_POST, QS_DEV,
                       3'd1, 3'd2, 3'd3, QS_POST};
            clear();
        endfunction

        function void clear();
            ph = PH_LEAD;
            wm = 0;
            acc = 0;
            epoch = 0;
            rel_cnt = 0;
            pre_kind = RANK_NONE;
            pre_val = 0;
            post_val = 0;
            dev_val = 0;
            pre_seen = 0;
            post_on = 0;
            dev_on = 0;
            dash_post = 0;
            qsel = 0;
            held_sep = 0;
            foreach (wbuf[i]) wbuf[i] = 0;
        endfunction

        function longint unsigned add_digit(longint unsigned a, int unsigned d);
            if (a > (NUM_TOP - d) / 10) return NUM_TOP;
            return a * 10 + d;
        endfunction

        function void close_string();
            if (!pre_seen && dev_on && !post_on) pre_kind = RANK_DEV_ONLY;
            ph = PH_FIN_OK;
        endfunction

        function bit commit(longint unsigned n);
            if (qsel == QS_POST) begin
                post_val = n;
                post_on = 1;
            end else if (qsel == QS_DEV) begin
                dev_val = n;
                dev_on = 1;
            end else begin
                if (pre_seen) begin
                    ph = PH_FIN_BAD;
                    return 0;
                end
                pre_seen = 1;
                pre_kind = qsel;
                pre_val = n;
            end
            return 1;
        endfunction

        function void match_word(byte unsigned c);
            byte unsigned lc;
            byte unsigned rest [8];
            int unsigned t, n, wlen, chosen;
            bit ok;
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            chosen = 12;
            wlen = 0;
            wbuf[wm & 7] = lc;
            t = (wm & 7) + 1;
            for (int i = 0; i < 12; i++) begin
                n = (words[i].len() < t) ? words[i].len() : t;
                ok = 1;
                for (int j = 0; j < n; j++)
                    if (words[i][j] != wbuf[j]) ok = 0;
                if (!ok) continue;
                if (words[i].len() > t) begin
                    wm = t;
                    return;
                end
                chosen = i;
                break;
            end
            if (chosen < 12) begin
                qsel = effect[chosen];
                wlen = words[chosen].len();
            end else if (dash_post && wbuf[0] >= CH_0 && wbuf[0] <= CH_9) begin
                qsel = QS_POST;
                wlen = 0;
            end else begin
                ph = PH_FIN_BAD;
                return;
            end
            rest = wbuf;
            wm = 0;
            ph = PH_QAFTER;
            for (int j = wlen; j < t; j++) feed(rest[j]);
        endfunction

        function void feed(byte unsigned c);
            bit dig, sep;
            int unsigned d;
            byte unsigned s;
            dig = c >= CH_0 && c <= CH_9;
            sep = c == CH_DOT || c == CH_DASH || c == CH_USCORE;
            d = dig ? c - CH_0 : 0;
            case (ph)
                PH_LEAD: begin
                    if (c == CH_SPACE || c == CH_TAB) return;
                    if (c == CH_LV || c == CH_UV) begin
                        ph = PH_AFTER_V;
                        return;
                    end
                    if (dig) begin
                        acc = d;
                        ph = PH_FIRST;
                    end else ph = PH_FIN_BAD;
                end
                PH_AFTER_V: begin
                    if (dig) begin
                        acc = d;
                        ph = PH_FIRST;
                    end else ph = PH_FIN_BAD;
                end
                PH_FIRST: begin
                    if (dig) begin
                        acc = add_digit(acc, d);
                        return;
                    end
                    if (c == CH_BANG) begin
                        epoch = acc;
                        acc = 0;
                        ph = PH_BANG;
                        return;
                    end
                    ph = PH_REL;
                    feed(c);
                end
                PH_BANG: begin
                    if (dig) begin
                        acc = d;
                        ph = PH_REL;
                    end else ph = PH_FIN_BAD;
                end
                PH_REL: begin
                    if (dig) begin
                        acc = add_digit(acc, d);
                        return;
                    end
                    if (rel_cnt < MAX_REL) begin
                        rel[rel_cnt] = acc;
                        rel_cnt++;
                    end
                    acc = 0;
                    if (c == CH_DOT) begin
                        ph = PH_RDOT;
                        return;
                    end
                    ph = PH_QTOP;
                    feed(c);
                end
                PH_RDOT: begin
                    if (dig) begin
                        if (rel_cnt >= MAX_REL) ph = PH_FIN_BAD;
                        else begin
                            acc = d;
                            ph = PH_REL;
                        end
                        return;
                    end
                    ph = PH_QTOP;
                    feed(CH_DOT);
                    feed(c);
                end
                PH_QTOP: begin
                    if (c == CH_NUL) begin
                        close_string();
                        return;
                    end
                    if (c == CH_PLUS) begin
                        ph = PH_TAIL;
                        return;
                    end
                    dash_post = (c == CH_DASH);
                    ph = PH_QSEP;
                    if (!sep) feed(c);
                end
                PH_QSEP: begin
                    if (sep) return;
                    if (c == CH_NUL) begin
                        close_string();
                        return;
                    end
                    if (c == CH_PLUS) begin
                        ph = PH_TAIL;
                        return;
                    end
                    ph = PH_QWORD;
                    wm = 0;
                    feed(c);
                end
                PH_QWORD: match_word(c);
                PH_QAFTER: begin
                    if (dig) begin
                        acc = d;
                        ph = PH_QNUM;
                        return;
                    end
                    if (sep) begin
                        held_sep = c;
                        ph = PH_QASEP;
                        return;
                    end
                    if (commit(0)) begin
                        ph = PH_QTOP;
                        feed(c);
                    end
                end
                PH_QASEP: begin
                    if (dig) begin
                        acc = d;
                        ph = PH_QNUM;
                        return;
                    end
                    if (commit(0)) begin
                        s = held_sep;
                        ph = PH_QTOP;
                        feed(s);
                        feed(c);
                    end
                end
                PH_QNUM: begin
                    if (dig) begin
                        acc = add_digit(acc, d);
                        return;
                    end
                    if (commit(acc)) begin
                        acc = 0;
                        ph = PH_QTOP;
                        feed(c);
                    end
                end
                PH_TAIL: if (c == CH_NUL) close_string();
                default: ;
            endcase
        endfunction

        function void push_key(logic [2:0] kind, logic [2:0] rank,
                               longint unsigned n, bit pres);
            t_out_item o;
            o.key_kind  = kind;
            o.qual_rank = rank;
            o.number    = n[31:0];
            o.present   = pres;
            o.run_end   = 0;
            key_q.push_back(o);
        endfunction

        function void note_input(t_in_item it);
            t_out_item last;
            items++;
            feed(it.char_code);
            if (!it.final_char) return;
            feed(CH_NUL);
            strings_done++;
            if (ph != PH_FIN_OK) begin
                invalid_runs++;
                push_key(KIND_INVALID, 3'd0, 0, 0);
            end else begin
                push_key(KIND_EPOCH, 3'd0, epoch, 0);
                for (int i = 0; i < rel_cnt; i++) push_key(KIND_RELEASE, 3'd0, rel[i], 0);
                push_key(KIND_PRE, pre_kind, pre_val, 0);
                push_key(KIND_POST, 3'd0, post_on ? post_val : 0, post_on);
                push_key(KIND_DEV, 3'd0, dev_on ? dev_val : 0, dev_on);
            end
            last = key_q.pop_back();
            last.run_end = 1;
            key_q.push_back(last);
            clear();
        endfunction

        function void check_key(t_out_item got);
            t_out_item want;
            keys_seen++;
            if (key_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected key item: kind %0d rank %0d number %0d",
                             got.key_kind, got.qual_rank, got.number);
                return;
            end
            want = key_q.pop_front();
            if (got.key_kind !== want.key_kind || got.qual_rank !== want.qual_rank ||
                got.number !== want.number || got.present !== want.present ||
                got.run_end !== want.run_end) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Key item %0d: expected kind %0d rank %0d number %0d",
                             keys_seen, want.key_kind, want.qual_rank, want.number);
                    $display("    present %0d end %0d, got kind %0d rank %0d",
                             want.present, want.run_end, got.key_kind, got.qual_rank);
                    $display("    number %0d present %0d end %0d",
                             got.number, got.present, got.run_end);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    vkp_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycles;

    version_key_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_key(o_out);

    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_char(byte unsigned c, bit last);
        t_in_item it;
        it.char_code = c;
        it.final_char = last;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(byte unsigned s[$]);
        foreach (s[i]) send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_text(string t);
        byte unsigned s[$];
        for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
        send_bytes(s);
    endtask

    function automatic void add_text(ref byte unsigned s[$], input string t);
        for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    endfunction

    function automatic void add_number(ref byte unsigned s[$]);
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            repeat ($urandom_range(10, 12)) s.push_back(8'(CH_0 + $urandom_range(9)));
        end else begin
            add_text(s, $sformatf("%0d", $urandom_range(0, (r < 5) ? 9 : 9999)));
        end
    endfunction

    function automatic void make_version(ref byte unsigned s[$]);
        string quals [15] = '{"alpha", "beta", "preview", "pre", "rc", "post", "rev",
                              "dev", "a", "b", "c", "r", "foo", "alp", "-"};
        string seps [4] = '{"", ".", "-", "_"};
        string w;
        int nparts;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(3) == 0) s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(3) == 0) s.push_back($urandom_range(1) ? CH_LV : CH_UV);
        if ($urandom_range(4) == 0) begin
            add_number(s);
            s.push_back(CH_BANG);
        end
        nparts = ($urandom_range(19) == 0) ? $urandom_range(8, 9) : $urandom_range(1, 4);
        for (int i = 0; i < nparts; i++) begin
            if (i > 0) s.push_back(CH_DOT);
            add_number(s);
        end
        repeat ($urandom_range(0, 3)) begin
            add_text(s, seps[$urandom_range(3)]);
            w = quals[$urandom_range(14)];
            if (w == "-") begin
                s.push_back(CH_DASH);
                add_number(s);
                continue;
            end
            for (int i = 0; i < w.len(); i++)
                s.push_back($urandom_range(1) ? w[i] - 8'd32 : w[i]);
            if ($urandom_range(3) != 0) begin
                add_text(s, seps[$urandom_range(3)]);
                add_number(s);
            end
        end
        if ($urandom_range(5) == 0) add_text(s, "+loc.5");
        if ($urandom_range(14) == 0) begin
            s.push_back(CH_NUL);
            s.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
    endfunction

    task automatic drain_keys();
        i_in_valid <= 0;
        while (sb.key_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        byte unsigned s[$];
        int pcts_idle [4] = '{0, 51, 0, 22};
        int pcts_stall [4] = '{0, 0, 51, 22};
        sb = new();
        cycles = 0;
        hold_left = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_text("7");
        send_text(" \tv2!3.4a1.post5.dev6+loc.al");
        send_text("1.2.3.4.5.6.7.8");
        send_text("1.2.3.4.5.6.7.8.9");
        send_text("99999999999.0rc");
        send_text("1.0-7");
        send_text("1.0.dev");
        send_text("1.0a1b2");
        send_text("V1.0PREVIEW_3-rev.dev2.post9");
        send_text("x1");
        send_text("1!");
        send_text("1.0foo");
        send_text("1.0c.r");
        s = '{CH_0 + 8'd1, CH_DOT, CH_0, CH_NUL, 8'hff, 8'h80};
        send_bytes(s);
        drain_keys();

        for (int p = 0; p < 4; p++) begin
            idle_pct = pcts_idle[p];
            stall_pct = pcts_stall[p];
            if (p == 2) hold_left = 400;
            while (sb.items < ITEM_TARGET * (p + 1) / 4) begin
                s.delete();
                make_version(s);
                send_bytes(s);
            end
            i_in_valid <= 0;
            drain_keys();
        end

        $display("Covered %0d characters in %0d strings, %0d key items, %0d invalid runs.",
                 sb.items, sb.strings_done, sb.keys_seen, sb.invalid_runs);
        if (sb.key_q.size() != 0)
            $display("%0d key items never arrived.", sb.key_q.size());
        if (sb.mismatches == 0 && sb.key_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
